/* rtl/core/assert_macros.svh */
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property holds at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

/* rtl/core/csc_pkg.sv */
// Package: constants, register codes and types of the star counter
`default_nettype none

package csc_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int PIXEL_BITS = 8;

   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int DIM_BITS   = 11;
   localparam int THR_BITS   = 8;
   localparam int COUNT_BITS = 20;
   localparam int SUM_BITS   = PIXEL_BITS + 3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [DIM_BITS-1:0] MIN_DIM      = DIM_BITS'(3);
   localparam logic [DIM_BITS-1:0] MAX_WIDTH_D  = DIM_BITS'(MAX_WIDTH);
   localparam logic [DIM_BITS-1:0] MAX_HEIGHT_D = DIM_BITS'(MAX_HEIGHT);

   // CSR map
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 11;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESHOLD    = 2'd2;

   localparam logic [DIM_BITS-1:0] RST_IMAGE_WIDTH  = DIM_BITS'(8);
   localparam logic [DIM_BITS-1:0] RST_IMAGE_HEIGHT = DIM_BITS'(6);
   localparam logic [THR_BITS-1:0] RST_THRESHOLD    = THR_BITS'(6);

   // Position info that travels with a pixel into the stencil stage
   typedef struct packed {
      logic                interior;
      logic                last;
      logic [COL_BITS-1:0] col;
   } pix_tag_type;

endpackage

`default_nettype wire

/* rtl/core/cross_stencil_star_counter.sv */
// Top level: five-point cross threshold star counter
//
// Pixels enter on the req_ channel in row-major order, one beat per pixel,
// and a new pixel is taken every cycle while req_ready is high. Interior
// pixels whose cross sum (centre plus four neighbours) exceeds 5 *
// brightness_threshold are counted. The pixel that closes a frame yields
// one rsp_ beat carrying the frame's star count; rsp_valid rises once that
// pixel has passed the s1 and output registers; no other pixel yields a beat.
// Throughput is one pixel per clock while req_ready is high, set by the
// single read and single write port of each line RAM used once per pixel.
// The csr_ port writes image_width, image_height and brightness_threshold;
// write it only between frames or while no pixel is in flight.
// Reset (synchronous) returns the registers to 8 x 6 and threshold 6, the
// position to the frame start and the count to zero; line RAM contents are
// not cleared and need no clearing pass.
// While a result waits for rsp_ready, pixels keep flowing; only the pixel
// that ends the next frame waits for the output register to drain.
`default_nettype none
`include "assert_macros.svh"

module cross_stencil_star_counter
   import csc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [PIXEL_BITS-1:0]    req_pixel_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic      [COUNT_BITS-1:0]    rsp_star_count,
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wr_data
);

   logic [DIM_BITS-1:0]   width_ff, width_in;
   logic [DIM_BITS-1:0]   height_ff, height_in;
   logic [THR_BITS-1:0]   thr_ff, thr_in;

   logic                  accept;
   pix_tag_type           s0_tag;
   logic                  s1_valid_ff;
   pix_tag_type           s1_tag_ff;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic [PIXEL_BITS-1:0] mid_data, up_data;
   logic                  result_valid;
   logic [COUNT_BITS-1:0] result_count;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic                  slot_free;
   logic                  frame_end_beat;

   // CSR decode
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thr_in    = thr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wr_data[DIM_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wr_data[DIM_BITS-1:0];
            CSR_THRESHOLD:    thr_in    = csr_wr_data[THR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
         thr_ff    <= RST_THRESHOLD;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         thr_ff    <= thr_in;
      end
   end

   // Only a frame-ending pixel needs the output register free next cycle
   assign req_ready = !s0_tag.last || !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   csc_position u_position (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .image_width  (width_ff),
      .image_height (height_ff),
      .tag          (s0_tag)
   );

   // Line RAMs: read at accept, written back in the following cycle at the same column
   csc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_middle_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_tag_ff.col),
      .wr_data (s1_pixel_ff),
      .rd_en   (accept),
      .rd_addr (s0_tag.col),
      .rd_data (mid_data)
   );

   csc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_upper_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_tag_ff.col),
      .wr_data (mid_data),
      .rd_en   (accept),
      .rd_addr (s0_tag.col),
      .rd_data (up_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tag_ff   <= s0_tag;
         s1_pixel_ff <= req_pixel_value;
      end
   end

   csc_stencil u_stencil (
      .clock        (clock),
      .reset        (reset),
      .s1_valid     (s1_valid_ff),
      .s1_tag       (s1_tag_ff),
      .s1_pixel     (s1_pixel_ff),
      .mid_data     (mid_data),
      .up_data      (up_data),
      .threshold    (thr_ff),
      .result_valid (result_valid),
      .result_count (result_count)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_valid) begin
         rsp_count_ff <= result_count;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_star_count = rsp_count_ff;

   assign slot_free      = !rsp_valid_ff || rsp_ready;
   assign frame_end_beat = accept && s0_tag.last;

   `ASSERT_PROP(a_result_slot_free, clock, reset, result_valid |-> slot_free, "beat overwritten")
   `ASSERT_PROP(a_last_gives_rsp, clock, reset, frame_end_beat |=> ##1 rsp_valid, "no result")
   `ASSERT_NEVER(a_no_adjacent_ends, clock, reset, frame_end_beat && result_valid, "double end")

endmodule

`default_nettype wire

/* rtl/core/csc_ram.sv */
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module csc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/csc_position.sv */
// Column and row position counters with frame geometry clamping
`default_nettype none

module csc_position
   import csc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [DIM_BITS-1:0] image_width,
   input  wire logic [DIM_BITS-1:0] image_height,
   output pix_tag_type              tag
);

   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [DIM_BITS-1:0] width_cl, height_cl;
   logic [DIM_BITS-1:0] col_next, row_next;
   logic                row_end, frame_end;

   always_comb begin
      if (image_width < MIN_DIM) begin
         width_cl = MIN_DIM;
      end else if (image_width > MAX_WIDTH_D) begin
         width_cl = MAX_WIDTH_D;
      end else begin
         width_cl = image_width;
      end
      if (image_height < MIN_DIM) begin
         height_cl = MIN_DIM;
      end else if (image_height > MAX_HEIGHT_D) begin
         height_cl = MAX_HEIGHT_D;
      end else begin
         height_cl = image_height;
      end
   end

   assign col_next  = DIM_BITS'(col_ff) + DIM_BITS'(1);
   assign row_next  = DIM_BITS'(row_ff) + DIM_BITS'(1);
   // ">=" so a geometry shrunk mid-frame still ends the row/frame
   assign row_end   = col_next >= width_cl;
   assign frame_end = row_end && (row_next >= height_cl);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_next[ROW_BITS-1:0];
         end else begin
            col_in = col_next[COL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign tag.interior = (row_ff >= ROW_BITS'(2)) && (col_ff >= COL_BITS'(2));
   assign tag.last     = frame_end;
   assign tag.col      = col_ff;

endmodule

`default_nettype wire

/* rtl/core/csc_stencil.sv */
// Cross window, threshold compare and running star total
`default_nettype none

module csc_stencil
   import csc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  s1_valid,
   input  wire pix_tag_type           s1_tag,
   input  wire logic [PIXEL_BITS-1:0] s1_pixel,
   input  wire logic [PIXEL_BITS-1:0] mid_data,
   input  wire logic [PIXEL_BITS-1:0] up_data,
   input  wire logic [THR_BITS-1:0]   threshold,
   output logic                       result_valid,
   output logic      [COUNT_BITS-1:0] result_count
);

   // win1_ff/win2_ff: middle-row pixels at columns c-2 and c-1
   logic [PIXEL_BITS-1:0] win1_ff, win2_ff;
   logic [PIXEL_BITS-1:0] up_dly_ff, down_dly_ff;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [COUNT_BITS-1:0] total_upd;
   logic [SUM_BITS-1:0]   sum, thr_x5;
   logic                  hit;

   assign sum = SUM_BITS'(win1_ff) + SUM_BITS'(win2_ff) + SUM_BITS'(mid_data)
              + SUM_BITS'(up_dly_ff) + SUM_BITS'(down_dly_ff);
   assign thr_x5 = SUM_BITS'({threshold, 2'b00}) + SUM_BITS'(threshold);
   assign hit = s1_tag.interior && (sum > thr_x5) && (total_ff != COUNT_MAX);

   assign total_upd = hit ? total_ff + COUNT_BITS'(1) : total_ff;

   always_comb begin
      total_in = total_ff;
      if (s1_valid) begin
         total_in = s1_tag.last ? '0 : total_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid) begin
         win1_ff     <= win2_ff;
         win2_ff     <= mid_data;
         up_dly_ff   <= up_data;
         down_dly_ff <= s1_pixel;
      end
   end

   assign result_valid = s1_valid && s1_tag.last;
   assign result_count = total_upd;

endmodule

`default_nettype wire

/* test/cross_stencil_star_counter_tb.sv */
// Testbench for the star counter: directed table, then random frames against a predictor
`default_nettype none

module cross_stencil_star_counter_tb;
   import csc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 4;       // pipeline is two deep; a little margin
   localparam int TAIL_CYCLES   = 8;
   localparam int LIMIT_CYCLES  = 800000;
   localparam int PHASE_PIXELS  = 140;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [0:0] {STEP_CSR, STEP_PIXELS} step_kind_type;

   typedef struct packed {
      step_kind_type             kind;
      logic [CSR_IDX_BITS-1:0]   idx;
      logic [CSR_DATA_BITS-1:0]  data;   // register value or pixel value
      logic [11:0]               reps;
      logic                      fixed;  // typed-in count instead of predicted
      logic [COUNT_BITS-1:0]     count;
   } step_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [PIXEL_BITS-1:0]    req_pixel_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [COUNT_BITS-1:0]    rsp_star_count;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wr_data = '0;

   cross_stencil_star_counter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_star_count  (rsp_star_count),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [DIM_BITS-1:0]   cfg_width  = RST_IMAGE_WIDTH;
   logic [DIM_BITS-1:0]   cfg_height = RST_IMAGE_HEIGHT;
   logic [THR_BITS-1:0]   cfg_thresh = RST_THRESHOLD;
   bit [PIXEL_BITS-1:0]   upper_line  [MAX_WIDTH];
   bit [PIXEL_BITS-1:0]   middle_line [MAX_WIDTH];
   bit [PIXEL_BITS-1:0]   mid_win     [3];
   bit [PIXEL_BITS-1:0]   up_hold;
   bit [PIXEL_BITS-1:0]   down_hold;
   int                    col_pos;
   int                    row_pos;
   int unsigned           star_total;

   logic [COUNT_BITS-1:0] star_count_q [$];
   int                    errors = 0;
   int                    send_idle = 36;
   int                    recv_idle = 82;
   int                    cycle_count = 0;

   function automatic int dim_in_use(input logic [DIM_BITS-1:0] v, input int hi);
      if (int'(v) < 3) return 3;
      if (int'(v) > hi) return hi;
      return int'(v);
   endfunction

   // Advance the frame model by one pixel; returns 1 when the pixel closes the frame.
   function automatic bit step_pixel(input logic [PIXEL_BITS-1:0] pix,
                                     output logic [COUNT_BITS-1:0] count);
      int w;
      int h;
      int c;
      int r;
      int cross_sum;
      bit [PIXEL_BITS-1:0] mid_px;
      bit [PIXEL_BITS-1:0] up_px;
      w = dim_in_use(cfg_width, MAX_WIDTH);
      h = dim_in_use(cfg_height, MAX_HEIGHT);
      c = col_pos;
      r = row_pos;
      count = '0;
      mid_px = middle_line[COL_BITS'(c)];
      up_px = upper_line[COL_BITS'(c)];
      mid_win[0] = mid_win[1];
      mid_win[1] = mid_win[2];
      mid_win[2] = mid_px;
      // centre (r-1, c-1) has all four neighbours once (r, c) arrives
      if (r >= 2 && c >= 2) begin
         cross_sum = int'(mid_win[0]) + int'(mid_win[1]) + int'(mid_win[2])
                   + int'(up_hold) + int'(down_hold);
         if (cross_sum > 5 * int'(cfg_thresh) && star_total < COUNT_MAX)
            star_total++;
      end
      up_hold = up_px;
      down_hold = pix;
      upper_line[COL_BITS'(c)] = mid_px;
      middle_line[COL_BITS'(c)] = pix;
      if (c + 1 >= w) begin
         col_pos = 0;
         if (r + 1 >= h) begin
            count = star_total[COUNT_BITS-1:0];
            star_total = 0;
            row_pos = 0;
            return 1'b1;
         end
         row_pos = r + 1;
      end else begin
         col_pos = c + 1;
      end
      return 1'b0;
   endfunction

   task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix, input bit fixed,
                             input logic [COUNT_BITS-1:0] fixed_count);
      logic [COUNT_BITS-1:0] predicted;
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_value <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (step_pixel(pix, predicted))
         star_count_q.push_back(fixed ? fixed_count : predicted);
   endtask

   // hold off the sender until the frame count is out and the pipe is empty
   task automatic drain;
      req_valid <= 1'b0;
      while (star_count_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:  cfg_width = data;
         CSR_IMAGE_HEIGHT: cfg_height = data;
         CSR_THRESHOLD:    cfg_thresh = data[THR_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic reconfigure(input logic [CSR_DATA_BITS-1:0] w,
                              input logic [CSR_DATA_BITS-1:0] h,
                              input logic [CSR_DATA_BITS-1:0] thr);
      drain();
      csr_write(CSR_IMAGE_WIDTH, w);
      csr_write(CSR_IMAGE_HEIGHT, h);
      csr_write(CSR_THRESHOLD, thr);
   endtask

   function automatic logic [PIXEL_BITS-1:0] pick_pixel(input int mode);
      int t;
      case (mode)
         0: return PIXEL_BITS'($urandom_range(0, 255));
         1: begin
            // hover around the threshold so the strict compare is exercised
            t = int'(cfg_thresh) + int'($urandom_range(0, 6)) - 3;
            if (t < 0) t = 0;
            if (t > 255) t = 255;
            return PIXEL_BITS'(t);
         end
         default: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      endcase
   endfunction

   task automatic random_frame(input int mode);
      int n;
      n = dim_in_use(cfg_width, MAX_WIDTH) * dim_in_use(cfg_height, MAX_HEIGHT);
      for (int i = 0; i < n; i++) send_pixel(pick_pixel(mode), 1'b0, '0);
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] pick_dim(input int hi);
      if ($urandom_range(0, 9) == 0) return CSR_DATA_BITS'($urandom_range(0, 2));
      return CSR_DATA_BITS'($urandom_range(3, hi));
   endfunction

   // receiver and result checker
   always @(posedge clock) begin : rsp_side
      logic [COUNT_BITS-1:0] want;
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
      if (!reset && rsp_valid && rsp_ready) begin
         if (star_count_q.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got star_count %0d",
                     $time, rsp_star_count);
            errors++;
         end else begin
            want = star_count_q.pop_front();
            if (rsp_star_count !== want) begin
               $display("%0t: star_count expected %0d, got %0d",
                        $time, want, rsp_star_count);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   step_type dir_steps [0:6];

   initial begin : stimulus
      int sent;
      step_type s;
      // reset geometry 8x6, threshold 6: flat 7s give sum 35 > 30 at all 24 interior pixels
      dir_steps[0] = '{STEP_PIXELS, CSR_IMAGE_WIDTH, 11'd7, 12'd48, 1'b1, 20'd24};
      // out-of-range sizes clamp to 3x3
      dir_steps[1] = '{STEP_CSR, CSR_IMAGE_WIDTH, 11'd2, 12'd1, 1'b0, 20'd0};
      dir_steps[2] = '{STEP_CSR, CSR_IMAGE_HEIGHT, 11'd0, 12'd1, 1'b0, 20'd0};
      dir_steps[3] = '{STEP_CSR, CSR_THRESHOLD, 11'd254, 12'd1, 1'b0, 20'd0};
      dir_steps[4] = '{STEP_PIXELS, CSR_IMAGE_WIDTH, 11'd255, 12'd9, 1'b1, 20'd1};
      // sum 1275 equals 5*255: strict compare, no star
      dir_steps[5] = '{STEP_CSR, CSR_THRESHOLD, 11'd255, 12'd1, 1'b0, 20'd0};
      dir_steps[6] = '{STEP_PIXELS, CSR_IMAGE_WIDTH, 11'd255, 12'd9, 1'b1, 20'd0};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i <= 6; i++) begin
         s = dir_steps[3'(i)];
         if (s.kind == STEP_CSR) begin
            drain();
            csr_write(s.idx, s.data);
         end else begin
            for (int k = 0; k < int'(s.reps); k++)
               send_pixel(s.data[PIXEL_BITS-1:0], s.fixed && (k == int'(s.reps) - 1),
                          s.count);
         end
      end

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin send_idle = 36; recv_idle = 82; end
            1: begin send_idle = 82; recv_idle = 36; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         // one long-row or tall frame per phase, rest kept small
         case (ph)
            0: reconfigure(11'd64, 11'd3, 11'd0);
            1: reconfigure(11'd1, 11'd64, 11'd255);
            default: reconfigure(11'd64, 11'd2, CSR_DATA_BITS'($urandom_range(0, 2047)));
         endcase
         random_frame(int'($urandom_range(0, 2)));
         if (ph == 2) begin
            drain();
            csr_write(CSR_UNUSED, CSR_DATA_BITS'($urandom_range(0, 2047)));
         end
         sent = 0;
         while (sent < PHASE_PIXELS) begin
            if (sent == 0 || $urandom_range(0, 1))
               reconfigure(pick_dim(8), pick_dim(6), CSR_DATA_BITS'($urandom_range(0, 2047)));
            sent += dim_in_use(cfg_width, MAX_WIDTH) * dim_in_use(cfg_height, MAX_HEIGHT);
            random_frame(int'($urandom_range(0, 2)));
         end
      end

      req_valid <= 1'b0;
      while (star_count_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
